### rtl/core/nrb_pkg.sv
// ============================================================================
// nrb_pkg
// Shared widths, reset values and parameter defaults for the n-th root
// bisection unit.
// ============================================================================
package nrb_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_RADICAND_BITS = 16;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_MAX_EXPONENT  = 8;

  // Fixed field widths
  localparam int EXP_BITS  = 4;
  localparam int ROOT_BITS = 32;
  localparam int TOL_BITS  = 17;

  // Tolerance register reset value, about 0.1 in UQ.16
  localparam logic [TOL_BITS-1:0] TOL_RESET = 17'd6554;

endpackage

### rtl/core/nth_root_bisection_unit.sv
// ============================================================================
// nth_root_bisection_unit
// Fixed-point n-th root of an unsigned integer by interval bisection, with a
// bit-serial shift-add multiplier raising each midpoint to the exponent.
// ============================================================================
//
// Usage:
//   Input channel (in_valid / in_stall) carries radicand and exponent. A beat
//   is taken when in_valid is high and in_stall is low; in_stall is high
//   while an item is being worked on.
//   Output channel (out_valid / out_stall) carries root_value (UQ16.16 at
//   default widths) and exact_hit. The result sits in an output register, so
//   the next item is accepted while a finished result still waits.
//   Configuration channel (tolerance_valid / tolerance_ready) writes the stop
//   width of the interval; tolerance_ready is always high. Write only while
//   the unit is idle.
//   Sequencing: each bisection step runs a check, then up to n-1 multiplier
//   passes, where n is the clamped exponent and W = RADICAND_BITS + FRAC_BITS;
//   each pass has the multiplier consuming one bit per cycle over W bits, and
//   a compare closes the step. Up to about W steps run, and one item is in
//   flight at a time.
//   Reset (rst, synchronous) empties the output register, returns to idle and
//   sets tolerance to its reset value. A stalled result holds until taken; a
//   new result then waits in the done state.
//
module nth_root_bisection_unit #(
  parameter int RADICAND_BITS = nrb_pkg::DEF_RADICAND_BITS,
  parameter int FRAC_BITS     = nrb_pkg::DEF_FRAC_BITS,
  parameter int MAX_EXPONENT  = nrb_pkg::DEF_MAX_EXPONENT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          tolerance_valid,
  output logic                          tolerance_ready,
  input  logic [nrb_pkg::TOL_BITS-1:0]  tolerance,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [RADICAND_BITS-1:0]      radicand,
  input  logic [nrb_pkg::EXP_BITS-1:0]  exponent,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nrb_pkg::ROOT_BITS-1:0] root_value,
  output logic                          exact_hit
);

  localparam int W   = RADICAND_BITS + FRAC_BITS;
  localparam int CW  = (W > nrb_pkg::TOL_BITS) ? W : nrb_pkg::TOL_BITS;
  localparam int KW  = $clog2(MAX_EXPONENT + 1);
  localparam int BCW = $clog2(W);
  localparam logic [BCW-1:0] BIT_LAST = BCW'(W - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MULCHK = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_POST   = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                   state;
  logic [nrb_pkg::TOL_BITS-1:0] tol_reg;
  logic [W-1:0]                 lo, hi, mid, target, pw;
  logic [W-1:0]                 acc_hi, acc_lo;
  logic [BCW-1:0]               bitcnt;
  logic [KW-1:0]                n_reg, k;
  logic                         hit;

  logic                         in_take, out_take;
  logic [4:0]                   exp5, max5, n5;
  logic [RADICAND_BITS-1:0]     rad_one;
  logic [nrb_pkg::TOL_BITS-1:0] tol_eff;
  logic [CW-1:0]                width_ext, tol_ext;
  logic [W:0]                   mid_sum, mul_sum;
  logic [2*W-1:0]               prod;
  logic                         prod_ovf;
  logic [W+nrb_pkg::ROOT_BITS-1:0] mid_ext;

  assign tolerance_ready = 1'b1;
  assign in_stall        = (state != S_IDLE);
  assign in_take         = in_valid && !in_stall;
  assign out_take        = out_valid && !out_stall;

  // clamp the exponent to 1..MAX_EXPONENT
  assign exp5 = {1'b0, exponent};
  assign max5 = 5'(MAX_EXPONENT);
  always_comb begin
    if (exp5 == 5'd0) begin
      n5 = 5'd1;
    end else if (exp5 > max5) begin
      n5 = max5;
    end else begin
      n5 = exp5;
    end
  end

  // upper bound is at least one
  assign rad_one = (radicand == '0) ? RADICAND_BITS'(1) : radicand;

  // stop test on interval width, zero tolerance acts as one
  assign tol_eff   = (tol_reg == '0) ? nrb_pkg::TOL_BITS'(1) : tol_reg;
  assign width_ext = CW'(hi - lo);
  assign tol_ext   = CW'(tol_eff);

  // midpoint and one shift-add multiplier step
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mul_sum  = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mid} : '0);
  assign prod     = {acc_hi, acc_lo};
  assign prod_ovf = (prod[2*W-1:W+FRAC_BITS] != '0);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol_reg <= nrb_pkg::TOL_RESET;
    end else if (tolerance_valid && tolerance_ready) begin
      tol_reg <= tolerance;
    end
  end

  // bisection sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            lo     <= '0;
            hi     <= {rad_one, {FRAC_BITS{1'b0}}};
            target <= {radicand, {FRAC_BITS{1'b0}}};
            mid    <= '0;
            hit    <= 1'b0;
            n_reg  <= KW'(n5);
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (width_ext > tol_ext) begin
            mid   <= mid_sum[W:1];
            pw    <= mid_sum[W:1];
            k     <= KW'(1);
            state <= S_MULCHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_MULCHK: begin
          if (k < n_reg) begin
            acc_hi <= '0;
            acc_lo <= pw;
            bitcnt <= '0;
            state  <= S_MUL;
          end else begin
            state <= S_CMP;
          end
        end
        S_MUL: begin
          // consume one multiplier bit per cycle
          acc_hi <= mul_sum[W:1];
          acc_lo <= {mul_sum[0], acc_lo[W-1:1]};
          bitcnt <= bitcnt + BCW'(1);
          if (bitcnt == BIT_LAST) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          // overflowing power counts as greater
          if (prod_ovf) begin
            hi    <= mid;
            state <= S_CHECK;
          end else begin
            pw    <= prod[W+FRAC_BITS-1:FRAC_BITS];
            k     <= k + KW'(1);
            state <= S_MULCHK;
          end
        end
        S_CMP: begin
          if (pw == target) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else if (pw > target) begin
            hi    <= mid;
            state <= S_CHECK;
          end else begin
            lo    <= mid;
            state <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: load a finished result, drop a taken beat
  assign mid_ext = {{nrb_pkg::ROOT_BITS{1'b0}}, mid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid  <= 1'b1;
      root_value <= mid_ext[nrb_pkg::ROOT_BITS-1:0];
      exact_hit  <= hit;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // bounds stay ordered while an item is in work
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DONE) |-> (lo <= hi))
    else $error("bisection bounds crossed");

  // power loop counter stays within the clamped exponent
  a_power_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULCHK) |-> (k >= KW'(1) && k <= n_reg))
    else $error("power loop count out of range");

  // a finished result waits while the output register is held
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("result dropped while output stalled");

  // exponent register never exceeds the maximum
  a_exp_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (n_reg >= KW'(1) && n_reg <= KW'(MAX_EXPONENT)))
    else $error("exponent not clamped");

endmodule
